// ----- design/hrgb_pkg.sv -----
// Shared types, widths and the gamma threshold table of the half-float RGB encoder.
// Used by every design module; depends on nothing else.
`default_nettype none

package hrgb_pkg;

	localparam int HALF_W = 16;
	localparam int BYTE_W = 8;
	localparam int MAG_W = 24;
	localparam int NUM_CH = 3;
	localparam int MANT_W = 10;
	localparam int EXPO_W = 5;
	localparam int PROD_W = MAG_W + BYTE_W;

	localparam int SEARCH_STEPS = BYTE_W;
	localparam int LANE_STAGES = SEARCH_STEPS + 1;
	localparam int NUM_STAGES = LANE_STAGES + 1;

	localparam logic [EXPO_W-1:0] EXPO_SPECIAL = 5'h1f;
	localparam logic [EXPO_W-1:0] EXPO_UNITY = 5'd15;
	localparam logic [EXPO_W-1:0] EXPO_SUBNORM = 5'd0;

	localparam logic [PROD_W-1:0] FULL_SCALE = PROD_W'(255);
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (MAG_W - 1);

	localparam int BIG_W = 224;
	localparam int GAMMA_LHS_POW = 5;
	localparam int GAMMA_RHS_POW = 11;
	localparam int GAMMA_RHS_SHIFT = 109;
	localparam int TABLE_DEPTH = 2 ** BYTE_W;

	typedef enum logic [1:0] {
		KIND_ZERO  = 2'd0,
		KIND_FULL  = 2'd1,
		KIND_VALUE = 2'd2
	} kind_t;

	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
	} pipe_ctrl_t;

	typedef logic [MAG_W-1:0] thr_table_t [TABLE_DEPTH];

	// True when m^5 * 255^11 reaches the given right-hand side.
	function automatic logic gamma_reaches(logic [MAG_W-1:0] m, logic [BIG_W-1:0] rhs);
		logic [BIG_W-1:0] lhs;
		int i;
		lhs = BIG_W'(1);
		for (i = 0; i < GAMMA_LHS_POW; i++) begin
			lhs = lhs * BIG_W'(m);
		end
		for (i = 0; i < GAMMA_RHS_POW; i++) begin
			lhs = lhs * BIG_W'(255);
		end
		return lhs >= rhs;
	endfunction

	// Entry k is the smallest magnitude whose gamma-encoded byte is at least k.
	function automatic thr_table_t build_thresholds();
		thr_table_t t;
		logic [BIG_W-1:0] rhs;
		logic [MAG_W:0] lo;
		logic [MAG_W:0] hi;
		logic [MAG_W:0] mid;
		int k;
		int i;
		int it;
		t[0] = '0;
		for (k = 1; k < TABLE_DEPTH; k++) begin
			rhs = BIG_W'(1);
			for (i = 0; i < GAMMA_RHS_POW; i++) begin
				rhs = rhs * BIG_W'(2 * k - 1);
			end
			rhs = rhs << GAMMA_RHS_SHIFT;
			lo = '0;
			hi = {1'b0, {MAG_W{1'b1}}};
			for (it = 0; it <= MAG_W; it++) begin
				if (lo < hi) begin
					mid = (lo + hi) >> 1;
					if (gamma_reaches(mid[MAG_W-1:0], rhs)) begin
						hi = mid;
					end else begin
						lo = mid + 1'b1;
					end
				end
			end
			t[k] = lo[MAG_W-1:0];
		end
		return t;
	endfunction

	localparam thr_table_t GAMMA_THR = build_thresholds();

endpackage

`default_nettype wire

// ----- design/half_rgb_to_rgb8_encoder_core.sv -----
// Half-float RGB pixel stream to 8-bit RGB encoder, top level.
// Depends on hrgb_pkg, hrgb_pipe_ctrl and hrgb_lane.
//
// Usage:
// Pixels enter on the s_ stream, one item per pixel with the red, green and
// blue binary16 words in s_tdata and the end-of-frame mark in s_tlast.
// Encoded pixels leave on the m_ stream with the same frame mark on m_tlast.
// The cfg channel writes the display-referred flag; it is always ready and
// should only be written while no pixel is in flight.
// Three channel lanes work side by side and a merging register joins them.
// The pipeline has ten register stages: one decode stage, eight gamma search
// stages and the merging register.
// Throughput is one pixel per clock while the receiver keeps m_tready high.
// When the receiver stalls, results wait in place and empty stages still
// fill, so s_tready drops only once every stage holds a pixel.
// Reset empties the pipeline and clears the flag, so gamma is applied.
`default_nettype none

module half_rgb_to_rgb8_encoder_core (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         s_tvalid,
	output logic                                         s_tready,
	// red_half, green_half, blue_half
	input  logic [hrgb_pkg::NUM_CH*hrgb_pkg::HALF_W-1:0] s_tdata,
	input  logic                                         s_tlast,
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	// red_byte, green_byte, blue_byte
	output logic [hrgb_pkg::NUM_CH*hrgb_pkg::BYTE_W-1:0] m_tdata,
	output logic                                         m_tlast,
	input  logic                                         cfg_valid,
	output logic                                         cfg_ready,
	input  logic                                         cfg_data
);
	import hrgb_pkg::*;

	pipe_ctrl_t                   ctrl;
	logic                         display_referred_q;
	logic [NUM_CH*BYTE_W-1:0]     lane_bytes;
	logic [NUM_CH*BYTE_W-1:0]     out_data_s;
	logic                         last_s [1:NUM_STAGES];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_referred_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			display_referred_q <= cfg_data;
		end
	end

	hrgb_pipe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.ctrl     (ctrl)
	);

	for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
		hrgb_lane u_lane (
			.clk       (clk),
			.ctrl      (ctrl),
			.half_in   (s_tdata[c*HALF_W +: HALF_W]),
			.gamma_in  (!display_referred_q),
			.chan_byte (lane_bytes[c*BYTE_W +: BYTE_W])
		);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[0]) begin
			last_s[1] <= s_tlast;
		end
		for (int i = 2; i <= NUM_STAGES; i++) begin
			if (ctrl.load[i-1]) begin
				last_s[i] <= last_s[i-1];
			end
		end
		if (ctrl.load[NUM_STAGES-1]) begin
			out_data_s <= lane_bytes;
		end
	end

	assign m_tdata = out_data_s;
	assign m_tlast = last_s[NUM_STAGES];

endmodule

`default_nettype wire

// ----- design/hrgb_pipe_ctrl.sv -----
// Valid tracking and per-stage load enables for the encoder pipeline.
// Depends on hrgb_pkg for the stage count and the control struct.
`default_nettype none

module hrgb_pipe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output hrgb_pkg::pipe_ctrl_t ctrl
);
	import hrgb_pkg::*;

	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES-1:0] load;
	logic                  in_acc;
	logic                  out_acc;

	// A stage may take new contents when it is empty or its contents move on.
	always_comb begin
		int i;
		load[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || m_tready;
		for (i = NUM_STAGES - 2; i >= 0; i--) begin
			load[i] = !valid_q[i] || load[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (load[0]) begin
				valid_q[0] <= s_tvalid;
			end
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (load[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	assign s_tready = load[0];
	assign m_tvalid = valid_q[NUM_STAGES-1];
	assign ctrl.load = load;
	assign in_acc = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q == '0) |-> s_tready)
		else $error("empty pipeline refused an item");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		((&valid_q) && !m_tready) |-> !s_tready)
		else $error("full stalled pipeline accepted an item");

	a_item_count: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> ($countones(valid_q) == $past($countones(valid_q))
			+ int'($past(in_acc)) - int'($past(out_acc))))
		else $error("item lost or duplicated in pipeline");

endmodule

`default_nettype wire

// ----- design/hrgb_lane.sv -----
// One colour channel: half-float decode, display scaling and an 8-step gamma search.
// Depends on hrgb_pkg for widths, the threshold table and the control struct.
`default_nettype none

module hrgb_lane (
	input  logic                           clk,
	input  hrgb_pkg::pipe_ctrl_t           ctrl,
	input  logic [hrgb_pkg::HALF_W-1:0]    half_in,
	input  logic                           gamma_in,
	output logic [hrgb_pkg::BYTE_W-1:0]    chan_byte
);
	import hrgb_pkg::*;

	logic                  sign_d;
	logic [EXPO_W-1:0]     expo_d;
	logic [MANT_W-1:0]     mant_d;
	kind_t                 kind_d;
	logic [MAG_W-1:0]      mag_d;

	logic [MAG_W-1:0]      mag_s   [1:LANE_STAGES];
	kind_t                 kind_s  [1:LANE_STAGES];
	logic                  gamma_s [1:LANE_STAGES];
	logic [BYTE_W-1:0]     res_s   [1:LANE_STAGES];
	logic [BYTE_W-1:0]     disp_s  [1:LANE_STAGES];

	assign sign_d = half_in[HALF_W-1];
	assign expo_d = half_in[HALF_W-2:MANT_W];
	assign mant_d = half_in[MANT_W-1:0];

	always_comb begin
		mag_d = '0;
		if (expo_d == EXPO_SPECIAL) begin
			kind_d = (mant_d == '0 && !sign_d) ? KIND_FULL : KIND_ZERO;
		end else if (expo_d == EXPO_SUBNORM && mant_d == '0) begin
			kind_d = KIND_ZERO;
		end else if (sign_d) begin
			kind_d = KIND_ZERO;
		end else if (expo_d >= EXPO_UNITY) begin
			kind_d = KIND_FULL;
		end else begin
			kind_d = KIND_VALUE;
			if (expo_d == EXPO_SUBNORM) begin
				mag_d = MAG_W'(mant_d);
			end else begin
				mag_d = MAG_W'({1'b1, mant_d}) << (expo_d - 5'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[0]) begin
			mag_s[1]   <= mag_d;
			kind_s[1]  <= kind_d;
			gamma_s[1] <= gamma_in;
			res_s[1]   <= '0;
			disp_s[1]  <= '0;
		end
	end

	// Each stage settles one bit of the gamma byte, most significant first.
	for (genvar st = 2; st <= LANE_STAGES; st++) begin : g_step
		localparam logic [BYTE_W-1:0] BIT_MASK = BYTE_W'(1) << (BYTE_W - 1 - (st - 2));
		logic [BYTE_W-1:0] trial;
		logic [BYTE_W-1:0] res_d;
		logic [BYTE_W-1:0] disp_d;

		assign trial = res_s[st-1] | BIT_MASK;
		assign res_d = (mag_s[st-1] >= GAMMA_THR[trial]) ? trial : res_s[st-1];

		if (st == 2) begin : g_scale
			logic [PROD_W-1:0] scaled;
			assign scaled = PROD_W'(mag_s[st-1]) * FULL_SCALE + ROUND_HALF;
			assign disp_d = scaled[PROD_W-1:MAG_W];
		end else begin : g_carry
			assign disp_d = disp_s[st-1];
		end

		always_ff @(posedge clk) begin
			if (ctrl.load[st-1]) begin
				mag_s[st]   <= mag_s[st-1];
				kind_s[st]  <= kind_s[st-1];
				gamma_s[st] <= gamma_s[st-1];
				res_s[st]   <= res_d;
				disp_s[st]  <= disp_d;
			end
		end
	end

	always_comb begin
		unique case (kind_s[LANE_STAGES])
			KIND_ZERO:  chan_byte = '0;
			KIND_FULL:  chan_byte = '1;
			KIND_VALUE: chan_byte = gamma_s[LANE_STAGES] ? res_s[LANE_STAGES]
			                                             : disp_s[LANE_STAGES];
			default:    chan_byte = '0;
		endcase
	end

endmodule

`default_nettype wire
